@@ rtl/escaped_word_tokenizer_assert.svh @@
// Assertion macros used by the checker file ewt_checker.sv.
`ifndef ESCAPED_WORD_TOKENIZER_ASSERT_SVH
`define ESCAPED_WORD_TOKENIZER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define EWT_ASSERT_NOW(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error("ewt check failed");

// Next-cycle implication, sampled on i_clk, off while in reset.
`define EWT_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error("ewt check failed");

`endif

@@ rtl/ewt_pkg.sv @@
`default_nettype none

package ewt_pkg;

    typedef logic [1:0] t_kind;

    localparam t_kind KIND_BYTE = 2'd0;
    localparam t_kind KIND_END  = 2'd1;
    localparam t_kind KIND_ERR  = 2'd2;
    localparam t_kind KIND_NONE = 2'd3;

    typedef enum logic [1:0] {
        ESC_IDLE,
        ESC_SLASH,
        ESC_ZERO,
        ESC_DIGIT
    } t_esc;

    typedef enum logic [1:0] {
        QT_NONE,
        QT_OPEN,
        QT_CLOSED
    } t_quote;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam int MAX_RES = 3;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_res;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_oct(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_SEVEN);
    endfunction

endpackage

`default_nettype wire

@@ rtl/ewt_if.sv @@
`default_nettype none

interface ewt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface ewt_out_if;
    logic          valid;
    logic          ready;
    ewt_pkg::t_kind kind;
    logic [7:0]    data;
    logic          last;

    modport source (output valid, output kind, output data, output last, input ready);
    modport sink   (input valid, input kind, input data, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/escaped_word_tokenizer.sv @@
// Channel   Dir  Payload                 Word
// i_in      in   ch[7:0]                 one raw line byte, 0 ends the line
// o_out     out  kind[1:0] data[7:0] last one token result, last marks final of byte
//
// Each byte is decoded in the cycle it is accepted; its 1..3 results sit in a
// result buffer and leave one per cycle while o_out is ready.
// i_in.ready is high when the buffer is empty or its final result is being
// taken, so one-result bytes stream one per cycle, no bubble, unless o_out stalls.
// Synchronous active-low reset clears tokenizer state and empties the buffer.
// A stall on o_out holds the buffer and blocks i_in until its final result is taken.
`default_nettype none

module escaped_word_tokenizer (
    input  wire            i_clk,
    input  wire            i_rst_n,
    ewt_in_if.sink         i_in,
    ewt_out_if.source      o_out
);

    logic              r_in_word, n_in_word;
    ewt_pkg::t_quote   r_quote,   n_quote;
    ewt_pkg::t_esc     r_esc,     n_esc;
    logic [7:0]        r_held,    n_held;
    logic [7:0]        r_prev,    n_prev;
    logic              r_drop,    n_drop;

    ewt_pkg::t_res     r_res [ewt_pkg::MAX_RES];
    logic [1:0]        r_cnt;
    logic [1:0]        r_idx;
    logic              r_vld;

    ewt_pkg::t_res     c_res [ewt_pkg::MAX_RES];
    logic [1:0]        c_cnt;

    logic [7:0]        c;
    logic [1:0]        pre_n;
    logic [7:0]        pre0, pre1;
    logic              fresh;
    logic              fr_vld;
    ewt_pkg::t_res     fr;
    logic              out_last;
    logic              in_take;
    logic              out_take;

    assign c        = i_in.ch;
    assign out_last = (r_idx == (r_cnt - 2'd1));
    assign out_take = o_out.valid && o_out.ready;
    assign in_take  = i_in.valid && i_in.ready;

    assign i_in.ready  = !r_vld || (o_out.ready && out_last);
    assign o_out.valid = r_vld;
    assign o_out.kind  = r_res[r_idx].kind;
    assign o_out.data  = r_res[r_idx].data;
    assign o_out.last  = out_last;

    // tokenizer next state and results for the byte on i_in
    always_comb begin
        n_in_word = r_in_word;
        n_quote   = r_quote;
        n_esc     = r_esc;
        n_held    = r_held;
        n_prev    = r_prev;
        n_drop    = r_drop;
        pre_n     = 2'd0;
        pre0      = 8'h00;
        pre1      = 8'h00;
        fresh     = 1'b1;
        fr_vld    = 1'b0;
        fr        = '{kind: ewt_pkg::KIND_NONE, data: 8'h00};

        if (r_drop) begin
            fresh = 1'b0;
            if (c == ewt_pkg::CH_NUL) begin
                n_in_word = 1'b0;
                n_quote   = ewt_pkg::QT_NONE;
                n_esc     = ewt_pkg::ESC_IDLE;
                n_held    = 8'h00;
                n_prev    = 8'h00;
                n_drop    = 1'b0;
            end
        end else begin
            case (r_esc)
                ewt_pkg::ESC_SLASH: begin
                    n_esc = ewt_pkg::ESC_IDLE;
                    if (c == ewt_pkg::CH_N) begin
                        pre0 = ewt_pkg::CH_LF;  pre_n = 2'd1; n_prev = c; fresh = 1'b0;
                    end else if (c == ewt_pkg::CH_B) begin
                        pre0 = ewt_pkg::CH_BS;  pre_n = 2'd1; n_prev = c; fresh = 1'b0;
                    end else if (c == ewt_pkg::CH_T) begin
                        pre0 = ewt_pkg::CH_TAB; pre_n = 2'd1; n_prev = c; fresh = 1'b0;
                    end else if (c == ewt_pkg::CH_ZERO) begin
                        n_esc = ewt_pkg::ESC_ZERO;
                        fresh = 1'b0;
                    end else if (c == ewt_pkg::CH_NUL) begin
                        // trailing backslash stands for itself, then the line ends
                        pre0 = ewt_pkg::CH_BSL; pre_n = 2'd1; n_prev = ewt_pkg::CH_BSL;
                    end else begin
                        pre0 = c; pre_n = 2'd1; n_prev = c; fresh = 1'b0;
                    end
                end
                ewt_pkg::ESC_ZERO: begin
                    n_esc = ewt_pkg::ESC_IDLE;
                    if (ewt_pkg::is_oct(c)) begin
                        n_esc  = ewt_pkg::ESC_DIGIT;
                        n_held = c;
                        fresh  = 1'b0;
                    end else begin
                        pre0 = ewt_pkg::CH_ZERO; pre_n = 2'd1; n_prev = ewt_pkg::CH_ZERO;
                    end
                end
                ewt_pkg::ESC_DIGIT: begin
                    n_esc = ewt_pkg::ESC_IDLE;
                    if (ewt_pkg::is_oct(c)) begin
                        pre0   = {2'b00, r_held[2:0], c[2:0]};
                        pre_n  = 2'd1;
                        n_prev = c;
                        fresh  = 1'b0;
                    end else begin
                        // broken escape: emit the digits seen, reprocess this byte
                        pre0   = ewt_pkg::CH_ZERO;
                        pre1   = r_held;
                        pre_n  = 2'd2;
                        n_prev = r_held;
                    end
                    n_held = 8'h00;
                end
                default: ;
            endcase

            if (fresh) begin
                if (c == ewt_pkg::CH_NUL) begin
                    if (r_in_word) begin
                        fr_vld = 1'b1;
                        if (r_quote == ewt_pkg::QT_OPEN ||
                            (r_quote == ewt_pkg::QT_CLOSED && n_prev != ewt_pkg::CH_CLOSE))
                            fr.kind = ewt_pkg::KIND_ERR;
                        else
                            fr.kind = ewt_pkg::KIND_END;
                    end
                    n_in_word = 1'b0;
                    n_quote   = ewt_pkg::QT_NONE;
                    n_esc     = ewt_pkg::ESC_IDLE;
                    n_held    = 8'h00;
                    n_prev    = 8'h00;
                    n_drop    = 1'b0;
                end else if (!r_in_word && ewt_pkg::is_space(c)) begin
                    // separator between words
                end else if (r_in_word && ewt_pkg::is_space(c) &&
                             r_quote != ewt_pkg::QT_OPEN) begin
                    fr_vld = 1'b1;
                    if (r_quote == ewt_pkg::QT_CLOSED && n_prev != ewt_pkg::CH_CLOSE) begin
                        fr.kind = ewt_pkg::KIND_ERR;
                        n_drop  = 1'b1;
                    end else begin
                        fr.kind = ewt_pkg::KIND_END;
                    end
                    n_in_word = 1'b0;
                    n_quote   = ewt_pkg::QT_NONE;
                    n_esc     = ewt_pkg::ESC_IDLE;
                    n_held    = 8'h00;
                    n_prev    = 8'h00;
                end else begin
                    if (!r_in_word) begin
                        n_in_word = 1'b1;
                        n_quote   = (c == ewt_pkg::CH_OPEN) ? ewt_pkg::QT_OPEN
                                                            : ewt_pkg::QT_NONE;
                    end
                    if (c == ewt_pkg::CH_BSL) begin
                        n_esc = ewt_pkg::ESC_SLASH;
                    end else begin
                        if (c == ewt_pkg::CH_CLOSE)
                            n_quote = ewt_pkg::QT_CLOSED;
                        fr_vld  = 1'b1;
                        fr.kind = ewt_pkg::KIND_BYTE;
                        fr.data = c;
                        n_prev  = c;
                    end
                end
            end
        end
    end

    // pack the results in order; a byte with no result reports one KIND_NONE entry
    always_comb begin
        for (int k = 0; k < ewt_pkg::MAX_RES; k++)
            c_res[k] = '{kind: ewt_pkg::KIND_NONE, data: 8'h00};
        c_res[0] = '{kind: ewt_pkg::KIND_BYTE, data: pre0};
        c_res[1] = '{kind: ewt_pkg::KIND_BYTE, data: pre1};
        if (fr_vld)
            c_res[pre_n] = fr;
        c_cnt = pre_n + {1'b0, fr_vld};
        if (c_cnt == 2'd0) begin
            c_res[0] = '{kind: ewt_pkg::KIND_NONE, data: 8'h00};
            c_cnt    = 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_word <= 1'b0;
            r_quote   <= ewt_pkg::QT_NONE;
            r_esc     <= ewt_pkg::ESC_IDLE;
            r_held    <= 8'h00;
            r_prev    <= 8'h00;
            r_drop    <= 1'b0;
            r_vld     <= 1'b0;
            r_idx     <= 2'd0;
        end else begin
            if (in_take) begin
                r_in_word <= n_in_word;
                r_quote   <= n_quote;
                r_esc     <= n_esc;
                r_held    <= n_held;
                r_prev    <= n_prev;
                r_drop    <= n_drop;
                r_vld     <= 1'b1;
                r_idx     <= 2'd0;
            end else if (out_take) begin
                if (out_last)
                    r_vld <= 1'b0;
                else
                    r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_res <= c_res;
            r_cnt <= c_cnt;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ewt_checker.sv @@
`default_nettype none

`include "escaped_word_tokenizer_assert.svh"

module ewt_checker (
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            i_in_valid,
    input wire            i_in_ready,
    input wire            i_out_valid,
    input wire            i_out_ready,
    input wire [1:0]      i_out_kind,
    input wire [7:0]      i_out_data,
    input wire            i_out_last
);

    wire        c_marker   = i_out_valid && (i_out_kind != ewt_pkg::KIND_BYTE);
    wire [10:0] c_out_word = {i_out_kind, i_out_data, i_out_last};

    // markers, errors and idle reports always close the results of a byte
    `EWT_ASSERT_NOW(a_marker_is_last, c_marker, i_out_last)

    `EWT_ASSERT_NOW(a_marker_no_data, c_marker, i_out_data == 8'h00)

    // with nothing buffered the block must take a byte
    `EWT_ASSERT_NOW(a_empty_ready, !i_out_valid, i_in_ready)

    `EWT_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(c_out_word))

    // a taken byte always has a result waiting on the next cycle
    `EWT_ASSERT_NEXT(a_take_fills, i_in_valid && i_in_ready, i_out_valid)

endmodule

bind escaped_word_tokenizer ewt_checker u_ewt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.kind),
    .i_out_data  (o_out.data),
    .i_out_last  (o_out.last)
);

`default_nettype wire
